// ----- rtl/toy_riscv_execute_unit_macros.svh -----
// Assertion macros shared by the execute unit RTL.
`ifndef TOY_RISCV_EXECUTE_UNIT_MACROS_SVH
`define TOY_RISCV_EXECUTE_UNIT_MACROS_SVH

// Checked on every clock edge outside reset.
`define TRX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define TRX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/trx_pkg.sv -----
// Shared types, opcodes and constants of the execute unit.
`default_nettype none
package trx_pkg;

  localparam int XLEN  = 32;
  localparam int IDX_W = 5;
  localparam int CMD_W = 3;

  localparam int DEF_CORE_NUMBER    = 0;
  localparam int DEF_REGISTER_COUNT = 32;

  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SWAP = 3'd2;
  localparam logic [CMD_W-1:0] CMD_JAL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BNE  = 3'd4;

  localparam logic [XLEN-1:0]  PC_STEP      = 32'd4;
  localparam logic [IDX_W-1:0] CORE_REG_IDX = 5'd3;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [XLEN-1:0]  val;
  } trx_wr_t;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [IDX_W-1:0]       rd_idx;
    logic                   rd_v;
    logic [IDX_W-1:0]       rs1_idx;
    logic                   rs1_v;
    logic [IDX_W-1:0]       rs2_idx;
    logic                   rs2_v;
    logic signed [XLEN-1:0] offset;
    logic [XLEN-1:0]        inst_pc;
  } trx_item_t;

  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    trx_wr_t         a;
    trx_wr_t         b;
    logic            jumped;
  } trx_res_t;

endpackage
`default_nettype wire

// ----- rtl/trx_regfile.sv -----
// Register file: synchronous memory, valid bits for reset values, write forwarding.
`default_nettype none
module trx_regfile
  import trx_pkg::*;
#(
  parameter int REGISTER_COUNT = DEF_REGISTER_COUNT,
  parameter int CORE_NUMBER    = DEF_CORE_NUMBER
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx0,
  input  logic [IDX_W-1:0] rd_idx1,
  input  trx_wr_t          wr,
  output logic [XLEN-1:0]  op0,
  output logic [XLEN-1:0]  op1
);

  localparam int AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam logic [IDX_W:0] CNT = (IDX_W+1)'(REGISTER_COUNT);

  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
    if ({1'b0, idx} < CNT) return idx[AW-1:0];
    else return '0;
  endfunction

  function automatic logic [XLEN-1:0] reset_val(input logic [IDX_W-1:0] idx);
    if (idx == CORE_REG_IDX) return XLEN'(CORE_NUMBER);
    else return '0;
  endfunction

  logic [XLEN-1:0]           mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] valid_r;
  logic [XLEN-1:0]           q0_r, q1_r;
  logic                      qv0_r, qv1_r;
  logic [IDX_W-1:0]          a0_r, a1_r;
  trx_wr_t                   fwd_r;
  logic [AW-1:0]             ra0, ra1, wa;

  assign ra0 = to_addr(rd_idx0);
  assign ra1 = to_addr(rd_idx1);
  assign wa  = to_addr(wr.idx);

  always_ff @(posedge clk) begin
    if (wr.en) mem[wa] <= wr.val;
    if (rd_en) begin
      q0_r  <= mem[ra0];
      q1_r  <= mem[ra1];
      qv0_r <= valid_r[ra0];
      qv1_r <= valid_r[ra1];
      a0_r  <= rd_idx0;
      a1_r  <= rd_idx1;
    end
  end

  // fwd_r always holds the newest write, the one a read at the same edge misses
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      fwd_r.en <= 1'b0;
    end else if (wr.en) begin
      valid_r[wa] <= 1'b1;
      fwd_r       <= wr;
    end
  end

  always_comb begin
    if (fwd_r.en && fwd_r.idx == a0_r) op0 = fwd_r.val;
    else if (qv0_r) op0 = q0_r;
    else op0 = reset_val(a0_r);
    if (fwd_r.en && fwd_r.idx == a1_r) op1 = fwd_r.val;
    else if (qv1_r) op1 = q1_r;
    else op1 = reset_val(a1_r);
  end

endmodule
`default_nettype wire

// ----- rtl/trx_alu.sv -----
// Execute logic: operation decode, add/sub, swap, jump and branch resolution.
`default_nettype none
module trx_alu
  import trx_pkg::*;
(
  input  trx_item_t       item,
  input  logic [XLEN-1:0] op0,
  input  logic [XLEN-1:0] op1,
  input  logic [XLEN-1:0] pc,
  output trx_res_t        res
);

  always_comb begin
    res         = '0;
    res.next_pc = pc + PC_STEP;
    unique case (item.cmd) inside
      CMD_ADD, CMD_SUB: begin
        if (item.rd_v && item.rs1_v && item.rs2_v) begin
          res.a.en  = 1'b1;
          res.a.idx = item.rd_idx;
          res.a.val = (item.cmd == CMD_ADD) ? op0 + op1 : op0 - op1;
        end
      end
      CMD_SWAP: begin
        if (item.rs1_v && item.rs2_v) begin
          res.a.en  = 1'b1;
          res.a.idx = item.rs1_idx;
          res.a.val = op1;
          // a register swapped with itself reports one write only
          if (item.rs1_idx != item.rs2_idx) begin
            res.b.en  = 1'b1;
            res.b.idx = item.rs2_idx;
            res.b.val = op0;
          end
        end
      end
      CMD_JAL: begin
        if (item.rd_v) begin
          res.a.en    = 1'b1;
          res.a.idx   = item.rd_idx;
          res.a.val   = item.inst_pc + PC_STEP;
          res.next_pc = pc + item.offset;
          res.jumped  = 1'b1;
        end
      end
      CMD_BNE: begin
        // operands are rd and rs1 here
        if (item.rd_v && item.rs1_v && op0 != op1) begin
          res.next_pc = pc + item.offset;
          res.jumped  = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/toy_riscv_execute_unit.sv -----
// Top level of the execute unit: accept, register read, execute, write back, output.
// Path: an accepted item waits in s1_item_r, then its result is registered in out_res_r,
// which drives out_*. Throughput: one item per cycle while out_ready allows; after a swap
//   that writes two registers, input is held off, since the register file memory has a single write port.
// Reset: synchronous, active low; registers read as zero (entry 3 as CORE_NUMBER)
//   until written, the PC clears to zero, and no item is held.
`default_nettype none
`include "toy_riscv_execute_unit_macros.svh"
module toy_riscv_execute_unit
  import trx_pkg::*;
#(
  parameter int CORE_NUMBER    = DEF_CORE_NUMBER,
  parameter int REGISTER_COUNT = DEF_REGISTER_COUNT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CMD_W-1:0]       in_cmd,
  input  logic [IDX_W-1:0]       in_rd_index,
  input  logic                   in_rd_ok,
  input  logic [IDX_W-1:0]       in_rs1_index,
  input  logic                   in_rs1_ok,
  input  logic [IDX_W-1:0]       in_rs2_index,
  input  logic                   in_rs2_ok,
  input  logic signed [XLEN-1:0] in_offset,
  input  logic [XLEN-1:0]        in_inst_pc,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [XLEN-1:0]        out_next_pc,
  output logic                   out_write_a_en,
  output logic [IDX_W-1:0]       out_write_a_index,
  output logic signed [XLEN-1:0] out_write_a_value,
  output logic                   out_write_b_en,
  output logic [IDX_W-1:0]       out_write_b_index,
  output logic signed [XLEN-1:0] out_write_b_value,
  output logic                   out_jumped
);

  localparam logic [IDX_W:0] CNT = (IDX_W+1)'(REGISTER_COUNT);

  logic            s1_v_r;
  trx_item_t       s1_item_r;
  trx_item_t       in_item;
  trx_res_t        res;
  trx_res_t        out_res_r;
  logic            out_v_r;
  trx_wr_t         pend_r, pend_nxt;
  trx_wr_t         wr;
  logic [XLEN-1:0] pc_r, pc_nxt;
  logic [XLEN-1:0] op0, op1;
  logic            s1_fire, in_fire;
  logic            in_bne;

  always_comb begin
    in_item.cmd     = in_cmd;
    in_item.rd_idx  = in_rd_index;
    in_item.rd_v    = in_rd_ok && ({1'b0, in_rd_index} < CNT);
    in_item.rs1_idx = in_rs1_index;
    in_item.rs1_v   = in_rs1_ok && ({1'b0, in_rs1_index} < CNT);
    in_item.rs2_idx = in_rs2_index;
    in_item.rs2_v   = in_rs2_ok && ({1'b0, in_rs2_index} < CNT);
    in_item.offset  = in_offset;
    in_item.inst_pc = in_inst_pc;
  end

  assign in_bne   = (in_cmd == CMD_BNE);
  assign s1_fire  = s1_v_r && (!out_v_r || out_ready);
  // hold off input while the second write of a swap drains
  assign in_ready = (!s1_v_r || s1_fire) && !(s1_fire && res.b.en);
  assign in_fire  = in_valid && in_ready;

  trx_regfile #(
    .REGISTER_COUNT(REGISTER_COUNT),
    .CORE_NUMBER   (CORE_NUMBER)
  ) u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_fire),
    .rd_idx0(in_bne ? in_rd_index : in_rs1_index),
    .rd_idx1(in_bne ? in_rs1_index : in_rs2_index),
    .wr     (wr),
    .op0    (op0),
    .op1    (op1)
  );

  trx_alu u_alu (
    .item(s1_item_r),
    .op0 (op0),
    .op1 (op1),
    .pc  (pc_r),
    .res (res)
  );

  always_comb begin
    if (s1_fire) begin
      wr    = res.a;
      wr.en = res.a.en;
    end else begin
      wr = pend_r;
    end
    pend_nxt    = res.b;
    pend_nxt.en = s1_fire && res.b.en;
    pc_nxt      = s1_fire ? res.next_pc : pc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      pend_r.en <= 1'b0;
      pc_r      <= '0;
    end else begin
      pend_r <= pend_nxt;
      pc_r   <= pc_nxt;
      if (in_fire) s1_v_r <= 1'b1;
      else if (s1_fire) s1_v_r <= 1'b0;
      if (s1_fire) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_item_r <= in_item;
    if (s1_fire) out_res_r <= res;
  end

  assign out_valid         = out_v_r;
  assign out_next_pc       = out_res_r.next_pc;
  assign out_write_a_en    = out_res_r.a.en;
  assign out_write_a_index = out_res_r.a.idx;
  assign out_write_a_value = $signed(out_res_r.a.val);
  assign out_write_b_en    = out_res_r.b.en;
  assign out_write_b_index = out_res_r.b.idx;
  assign out_write_b_value = $signed(out_res_r.b.val);
  assign out_jumped        = out_res_r.jumped;

  `TRX_ASSERT(a_pend_excl, !(pend_r.en && s1_v_r), "pending swap write overlaps an item")
  `TRX_ASSERT(a_swap_drain, (s1_fire && res.b.en) |=> (pend_r.en && !s1_v_r), "swap write lost")
  `TRX_ASSERT(a_pc_hold, !s1_fire |=> $stable(pc_r), "PC moved without a completed item")
  `TRX_ASSERT_ALWAYS(a_rst_out, !rst_n |=> (!out_valid && !s1_v_r), "item held after reset")

endmodule
`default_nettype wire
